// ===== rtl/dwsd_pkg.sv =====
// shared types, constants and tables for the deformed woods-saxon density block
`default_nettype none
package dwsd_pkg;

   // spherical harmonic scale factors, Q24
   localparam logic signed [23:0] K2_Q24 = 24'sd5291392;
   localparam logic signed [21:0] K4_Q24 = 22'sd1774787;

   // log2(e) in Q16
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   // exponent argument limit, 16.0 in Q16
   localparam logic [20:0] ARG_LIMIT = 21'd1048576;

   // radius difference limit, 16 fm in Q11
   localparam logic signed [29:0] DIFF_LIMIT = 30'sd32768;

   // quotient bits of the two dividers
   localparam int ARG_STEPS  = 21;
   localparam int FRAC_STEPS = 17;

   typedef struct packed {
      logic               deform_enable;
      logic [15:0]        central_density;
      logic [15:0]        half_radius;
      logic [15:0]        diffuseness;
      logic signed [14:0] beta_two;
      logic signed [14:0] beta_four;
   } cfg_type;

   // 2^(-i/16) in Q16
   function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
      logic [16:0] val;
      case (idx)
         5'd0:    val = 17'd65536;
         5'd1:    val = 17'd62757;
         5'd2:    val = 17'd60097;
         5'd3:    val = 17'd57549;
         5'd4:    val = 17'd55109;
         5'd5:    val = 17'd52773;
         5'd6:    val = 17'd50535;
         5'd7:    val = 17'd48393;
         5'd8:    val = 17'd46341;
         5'd9:    val = 17'd44376;
         5'd10:   val = 17'd42495;
         5'd11:   val = 17'd40693;
         5'd12:   val = 17'd38968;
         5'd13:   val = 17'd37316;
         5'd14:   val = 17'd35734;
         5'd15:   val = 17'd34219;
         default: val = 17'd32768;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/dwsd_radius.sv =====
// deformed half-density radius pipeline, seven register stages
`default_nettype none
module dwsd_radius (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   input  wire [15:0]          in_radius,
   input  wire signed [15:0]   in_cosine,
   input  dwsd_pkg::cfg_type   cfg,
   output logic                out_valid,
   output logic [15:0]         out_radius,
   output logic signed [28:0]  out_big_r
);

   localparam int STAGES = 7;

   logic [STAGES-1:0] valid_ff;
   logic [15:0]       radius_ff [0:STAGES-1];

   logic signed [31:0] csq;
   logic [16:0]        c2_ff;
   logic [33:0]        c2sq;
   logic [18:0]        c4_ff;
   logic [16:0]        c2b_ff;
   logic signed [18:0] a20_in;
   logic signed [18:0] a20_ff;
   logic signed [42:0] p20_ff;
   logic signed [25:0] a40_in;
   logic signed [25:0] a40_ff;
   logic signed [17:0] y20_ff;
   logic signed [47:0] p40_ff;
   logic signed [22:0] y40;
   logic signed [32:0] t2_ff;
   logic signed [37:0] t4_ff;
   logic signed [39:0] factor_in;
   logic signed [39:0] factor_ff;
   logic signed [56:0] rprod_ff;

   assign csq    = in_cosine * in_cosine;
   assign c2sq   = {17'b0, c2_ff} * {17'b0, c2_ff};
   assign a20_in = signed'(19'({2'b0, c2_ff} * 19'd3)) - 19'sd16384;
   assign a40_in = signed'({7'b0, c4_ff}) * 26'sd35 - signed'({9'b0, c2b_ff}) * 26'sd30
                   + 26'sd49152;
   assign y40    = p40_ff[46:24];
   assign factor_in = 40'sd268435456 + 40'(t2_ff) + 40'(t4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      radius_ff[0] <= in_radius;
      for (int i = 1; i < STAGES; i++) begin
         radius_ff[i] <= radius_ff[i-1];
      end
      c2_ff     <= csq[30:14];
      c4_ff     <= c2sq[32:14];
      c2b_ff    <= c2_ff;
      a20_ff    <= a20_in;
      p20_ff    <= 43'(a20_ff) * 43'(dwsd_pkg::K2_Q24);
      a40_ff    <= a40_in;
      y20_ff    <= p20_ff[41:24];
      p40_ff    <= 48'(a40_ff) * 48'(dwsd_pkg::K4_Q24);
      t2_ff     <= 33'(cfg.beta_two) * 33'(y20_ff);
      t4_ff     <= 38'(cfg.beta_four) * 38'(y40);
      factor_ff <= factor_in;
      rprod_ff  <= 57'(signed'({1'b0, cfg.half_radius})) * 57'(factor_ff);
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_radius = radius_ff[STAGES-1];
   assign out_big_r  = cfg.deform_enable ? rprod_ff[56:28]
                                         : signed'({13'b0, cfg.half_radius});

endmodule
`default_nettype wire

// ===== rtl/dwsd_arg.sv =====
// clamped radius difference and pipelined divide by the diffuseness
`default_nettype none
module dwsd_arg (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   input  wire [15:0]          in_radius,
   input  wire signed [28:0]   in_big_r,
   input  dwsd_pkg::cfg_type   cfg,
   output logic                out_valid,
   output logic                out_neg,
   output logic [20:0]         out_arg
);

   localparam int STEPS = dwsd_pkg::ARG_STEPS;

   logic signed [29:0] diff;
   logic signed [29:0] dclamp;
   logic               neg;
   logic [15:0]        mag;
   logic [15:0]        dvsr;
   logic               sat;

   logic        valid_ff [0:STEPS];
   logic        neg_ff   [0:STEPS];
   logic        sat_ff   [0:STEPS];
   logic [15:0] rem_ff   [0:STEPS];
   logic [20:0] q_ff     [0:STEPS];

   assign diff = signed'({14'b0, in_radius}) - 30'(in_big_r);

   always_comb begin
      if (diff > dwsd_pkg::DIFF_LIMIT) begin
         dclamp = dwsd_pkg::DIFF_LIMIT;
      end else if (diff < -dwsd_pkg::DIFF_LIMIT) begin
         dclamp = -dwsd_pkg::DIFF_LIMIT;
      end else begin
         dclamp = diff;
      end
   end

   assign neg  = dclamp[29];
   assign mag  = neg ? 16'(-dclamp) : dclamp[15:0];
   // zero diffuseness acts as one
   assign dvsr = (cfg.diffuseness == 16'd0) ? 16'd1 : cfg.diffuseness;
   // quotient would reach 2^21 or more, twice the limit or beyond
   assign sat  = mag >= dvsr;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff[0] <= neg;
      sat_ff[0] <= sat;
      rem_ff[0] <= sat ? 16'd0 : mag;
      q_ff[0]   <= '0;
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic [16:0] rem2;
      logic        ge;

      assign rem2 = {rem_ff[i], 1'b0};
      assign ge   = rem2 >= {1'b0, dvsr};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         neg_ff[i+1] <= neg_ff[i];
         sat_ff[i+1] <= sat_ff[i];
         rem_ff[i+1] <= ge ? 16'(rem2 - {1'b0, dvsr}) : rem2[15:0];
         q_ff[i+1]   <= {q_ff[i][19:0], ge};
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_neg   = neg_ff[STEPS];
   assign out_arg   = (sat_ff[STEPS] || q_ff[STEPS] > dwsd_pkg::ARG_LIMIT)
                      ? dwsd_pkg::ARG_LIMIT : q_ff[STEPS];

endmodule
`default_nettype wire

// ===== rtl/dwsd_exp.sv =====
// exp(-x) by table and interpolation, fermi fraction divide, density scale
`default_nettype none
module dwsd_exp (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   input  wire                 in_neg,
   input  wire [20:0]          in_arg,
   input  dwsd_pkg::cfg_type   cfg,
   output logic                out_valid,
   output logic [15:0]         out_density
);

   localparam int STEPS = dwsd_pkg::FRAC_STEPS;

   logic [1:0]  valid_ff;
   logic        neg1_ff;
   logic        neg2_ff;
   logic [37:0] vprod_ff;

   logic [21:0] v;
   logic [3:0]  idx;
   logic [11:0] lo;
   logic [16:0] ta;
   logic [16:0] tb;
   logic [16:0] ta_ff;
   logic [28:0] mp_ff;
   logic [5:0]  k_ff;

   logic [16:0] m;
   logic [16:0] e;

   logic        dvalid_ff [0:STEPS];
   logic [17:0] rem_ff    [0:STEPS];
   logic [17:0] den_ff    [0:STEPS];
   logic [16:0] q_ff      [0:STEPS];

   logic [32:0] dprod;
   logic        rsp_valid_ff;
   logic [15:0] rsp_density_ff;

   assign v   = vprod_ff[37:16];
   assign idx = v[15:12];
   assign lo  = v[11:0];
   assign ta  = dwsd_pkg::pow2_neg({1'b0, idx});
   assign tb  = dwsd_pkg::pow2_neg(5'({1'b0, idx} + 5'd1));
   assign m   = ta_ff - 17'(mp_ff >> 12);
   assign e   = m >> k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      vprod_ff <= {17'b0, in_arg} * {21'b0, dwsd_pkg::LOG2E_Q16};
      neg1_ff  <= in_neg;
      ta_ff    <= ta;
      mp_ff    <= {12'b0, ta - tb} * {17'b0, lo};
      k_ff     <= v[21:16];
      neg2_ff  <= neg1_ff;
   end

   // fraction = X * 2^16 / (2^16 + e), X is 2^16 below the radius, e beyond it
   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff[0] <= 1'b0;
      end else begin
         dvalid_ff[0] <= valid_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= neg2_ff ? 18'd65536 : {1'b0, e};
      den_ff[0] <= 18'd65536 + {1'b0, e};
      q_ff[0]   <= '0;
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [18:0] rem_s;
      logic        ge;

      if (j == 0) begin : g_first
         assign rem_s = {1'b0, rem_ff[j]};
      end else begin : g_next
         assign rem_s = {rem_ff[j], 1'b0};
      end

      assign ge = rem_s >= {1'b0, den_ff[j]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dvalid_ff[j+1] <= 1'b0;
         end else begin
            dvalid_ff[j+1] <= dvalid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j+1] <= ge ? 18'(rem_s - {1'b0, den_ff[j]}) : rem_s[17:0];
         den_ff[j+1] <= den_ff[j];
         q_ff[j+1]   <= {q_ff[j][15:0], ge};
      end
   end

   assign dprod = {17'b0, cfg.central_density} * {16'b0, q_ff[STEPS]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dvalid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_density_ff <= dprod[31:16];
   end

   assign out_valid   = rsp_valid_ff;
   assign out_density = rsp_density_ff;

endmodule
`default_nettype wire

// ===== rtl/deformed_woods_saxon_density.sv =====
// top level: control registers and the density pipeline
//
//   channel   ports                                         beat taken when
//   request   start, busy, req_radius, req_polar_cosine     start && !busy
//   response  rsp_valid, rsp_density                        rsp_valid, one cycle
//   csr       csr_write_enable, csr_index, csr_write_data   csr_write_enable
//
// one beat enters every cycle; busy is always low
// a request passes the deformed radius, then the argument divide (one quotient bit
// a stage), then exp, the fraction divide and the output register
// reset clears the valid bits and loads the register defaults; payload is not reset
// no stall: the response beat appears once and is not held
`default_nettype none
module deformed_woods_saxon_density (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire [15:0]         req_radius,
   input  wire signed [15:0]  req_polar_cosine,
   output logic               rsp_valid,
   output logic [15:0]        rsp_density,
   input  wire                csr_write_enable,
   input  wire [2:0]          csr_index,
   input  wire [15:0]         csr_write_data
);

   typedef enum logic [2:0] {
      CSR_DEFORM_ENABLE   = 3'd0,
      CSR_CENTRAL_DENSITY = 3'd1,
      CSR_HALF_RADIUS     = 3'd2,
      CSR_DIFFUSENESS     = 3'd3,
      CSR_BETA_TWO        = 3'd4,
      CSR_BETA_FOUR       = 3'd5
   } csr_index_type;

   dwsd_pkg::cfg_type cfg_ff;

   logic               rad_valid;
   logic [15:0]        rad_radius;
   logic signed [28:0] rad_big_r;
   logic               arg_valid;
   logic               arg_neg;
   logic [20:0]        arg_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deform_enable   <= 1'b0;
         cfg_ff.central_density <= 16'd11141;
         cfg_ff.half_radius     <= 16'd13066;
         cfg_ff.diffuseness     <= 16'd35389;
         cfg_ff.beta_two        <= '0;
         cfg_ff.beta_four       <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEFORM_ENABLE:   cfg_ff.deform_enable   <= csr_write_data[0];
            CSR_CENTRAL_DENSITY: cfg_ff.central_density <= csr_write_data;
            CSR_HALF_RADIUS:     cfg_ff.half_radius     <= csr_write_data;
            CSR_DIFFUSENESS:     cfg_ff.diffuseness     <= csr_write_data;
            CSR_BETA_TWO:        cfg_ff.beta_two        <= signed'(csr_write_data[14:0]);
            CSR_BETA_FOUR:       cfg_ff.beta_four       <= signed'(csr_write_data[14:0]);
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   dwsd_radius u_radius (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start),
      .in_radius  (req_radius),
      .in_cosine  (req_polar_cosine),
      .cfg        (cfg_ff),
      .out_valid  (rad_valid),
      .out_radius (rad_radius),
      .out_big_r  (rad_big_r)
   );

   dwsd_arg u_arg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rad_valid),
      .in_radius (rad_radius),
      .in_big_r  (rad_big_r),
      .cfg       (cfg_ff),
      .out_valid (arg_valid),
      .out_neg   (arg_neg),
      .out_arg   (arg_value)
   );

   dwsd_exp u_exp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (arg_valid),
      .in_neg      (arg_neg),
      .in_arg      (arg_value),
      .cfg         (cfg_ff),
      .out_valid   (rsp_valid),
      .out_density (rsp_density)
   );

endmodule
`default_nettype wire
